@@ rtl/core/cts_pkg.sv @@
// Types, codes and helper functions shared by the camera trigger request sequencer.
`default_nettype none
package cts_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam logic [31:0] MARGIN_RESET = 32'd5000;

	localparam logic [1:0] FUNC_ENQ = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_STROBE = 2'd2;
	localparam logic [1:0] FUNC_CANCEL = 2'd3;

	localparam logic [2:0] KIND_ACCEPT = 3'd0;
	localparam logic [2:0] KIND_REFUSED = 3'd1;
	localparam logic [2:0] KIND_FINISHED = 3'd2;
	localparam logic [2:0] KIND_REJECTED = 3'd3;
	localparam logic [2:0] KIND_TRIGGER = 3'd4;

	localparam logic [2:0] RSN_NONE = 3'd0;
	localparam logic [2:0] RSN_CENTER = 3'd1;
	localparam logic [2:0] RSN_BAD_MASK = 3'd2;
	localparam logic [2:0] RSN_UNKNOWN = 3'd3;
	localparam logic [2:0] RSN_DUPLICATE = 3'd4;
	localparam logic [2:0] RSN_FULL = 3'd5;
	localparam logic [2:0] RSN_TIMEOUT = 3'd6;
	localparam logic [2:0] RSN_CANCELLED = 3'd7;

	localparam logic [2:0] CAMS_LR = 3'b110;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENQ,
		ST_TICK,
		ST_DROP,
		ST_FIN,
		ST_START,
		ST_CAN,
		ST_CAN_FIN,
		ST_DRAIN,
		ST_STROBE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] seq;
		logic [7:0]  stream;
		logic [2:0]  cameras;
		logic [31:0] pulse_us;
		logic [31:0] settle_us;
		logic        stream_known;
		logic [63:0] now_us;
		logic        strobe_camera;
		logic        strobe_level;
		logic [63:0] mirror_left;
		logic [63:0] mirror_right;
	} req_word_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] out_seq;
		logic [7:0]  out_stream;
		logic [31:0] capture_id;
		logic [63:0] trigger_start;
		logic [63:0] exposure_time;
		logic [63:0] avg_left;
		logic [63:0] avg_right;
		logic [2:0]  reason_code;
		logic [2:0]  queue_fill;
		logic [2:0]  trigger_mask_level;
		logic        last;
	} rsp_word_t;

	// cams: bit0 left, bit1 right
	typedef struct packed {
		logic [15:0] seq;
		logic [7:0]  stream;
		logic [1:0]  cams;
		logic [31:0] pulse;
		logic [31:0] settle;
		logic [31:0] capture_id;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} chain_ctl_t;

	function automatic logic [63:0] avg4(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] res;
		logic [16:0] s;
		res = '0;
		for (int i = 0; i < 4; i++) begin
			s = {1'b0, a[16*i +: 16]} + {1'b0, b[16*i +: 16]} + 17'd1;
			res[16*i +: 16] = s[16:1];
		end
		return res;
	endfunction

	function automatic rsp_word_t trig_row(input entry_t e, input logic lvl);
		rsp_word_t r;
		r = '0;
		r.kind = KIND_TRIGGER;
		r.out_seq = e.seq;
		r.out_stream = e.stream;
		r.capture_id = e.capture_id;
		r.trigger_mask_level = {e.cams, lvl};
		return r;
	endfunction

	function automatic rsp_word_t reject_row(input entry_t e, input logic [2:0] rsn);
		rsp_word_t r;
		r = '0;
		r.kind = KIND_REJECTED;
		r.out_seq = e.seq;
		r.out_stream = e.stream;
		r.capture_id = e.capture_id;
		r.reason_code = rsn;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/cts_cell.sv @@
// One queue cell: holds a request, takes its neighbor's on a pop or a new one on a load.
`default_nettype none
module cts_cell (
	input  wire logic            clk,
	input  wire logic            shift,
	input  wire logic            load,
	input  wire cts_pkg::entry_t nxt,
	input  wire cts_pkg::entry_t wr_entry,
	output cts_pkg::entry_t      entry
);

	cts_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= nxt;
		end else if (load) begin
			entry_q <= wr_entry;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

@@ rtl/core/cts_chain.sv @@
// Request queue as a row of cells shifting toward the head, with fill count and stream match.
`default_nettype none
module cts_chain #(
	parameter int DEPTH = cts_pkg::QUEUE_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cts_pkg::chain_ctl_t      ctl,
	input  wire cts_pkg::entry_t          wr_entry,
	input  wire logic [7:0]               match_stream,
	output cts_pkg::entry_t               head,
	output logic [$clog2(DEPTH+1)-1:0]    count,
	output logic                          full,
	output logic                          match
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	cts_pkg::entry_t cells [DEPTH];
	logic [DEPTH-1:0] hit;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cts_pkg::entry_t nxt;
		if (i == DEPTH - 1) begin : g_tail
			assign nxt = cells[i];
		end else begin : g_mid
			assign nxt = cells[i+1];
		end
		cts_cell u_cell (
			.clk(clk),
			.shift(ctl.pop),
			.load(ctl.push && (count_q == CW'(i))),
			.nxt(nxt),
			.wr_entry(wr_entry),
			.entry(cells[i])
		);
		assign hit[i] = (CW'(i) < count_q) && (cells[i].stream == match_stream);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push && !ctl.pop) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.pop && !ctl.push) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign head = cells[0];
	assign count = count_q;
	assign full = (count_q == CW'(DEPTH));
	assign match = |hit;

endmodule
`default_nettype wire

@@ rtl/core/camera_trigger_request_sequencer.sv @@
// Top level: event sequencer for camera trigger requests.
// Throughput: one word at a time; next word taken after the last result is in the output register.
// Each result waits for the output register; the chain pops one cell a cycle unless output stalls.
// Reset: async active low; queue empty, idle, margin 5000, no stream seen, times and latches zero.
`default_nettype none
module camera_trigger_request_sequencer #(
	parameter int QUEUE_DEPTH = cts_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire cts_pkg::req_word_t req_word,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output cts_pkg::rsp_word_t      rsp_word,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_data
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cts_pkg::state_t state_q, state_d;
	cts_pkg::req_word_t ev_q;
	cts_pkg::entry_t act_q, head, wr_entry;
	cts_pkg::chain_ctl_t ctl;
	cts_pkg::rsp_word_t row, pend_q, rsp_q, out_row;
	logic [CW-1:0] count;
	logic full, match;
	logic [31:0] margin_q, cnt_q;
	logic busy_q, dropped_q, settle_q, latched_q, finvalid_q;
	logic [1:0] high_q, risen_q, await_q;
	logic ls_valid_q;
	logic [7:0] ls_q;
	logic [63:0] t0_q, due_q, t2_q, el_q;
	logic [63:0] ml0_q, ml1_q, ml2_q, ml3_q;
	logic pend_v_q, rsp_v_q;
	logic need_emit, emit_ok, go, out_free, out_load;
	logic [2:0] cams_eff, reason;
	logic fire, drop, over, tout, start, hold;
	logic [1:0] sbit;

	assign out_free = !rsp_v_q || rsp_ready;
	assign emit_ok = !pend_v_q || out_free;
	assign go = !need_emit || emit_ok;
	assign out_load = (need_emit && go && pend_v_q) ||
		((state_q == cts_pkg::ST_DONE) && pend_v_q && out_free);

	assign wr_entry = '{seq: ev_q.seq, stream: ev_q.stream, cams: cams_eff[2:1],
		pulse: ev_q.pulse_us, settle: ev_q.settle_us, capture_id: cnt_q + 32'd1};

	cts_chain #(.DEPTH(QUEUE_DEPTH)) u_chain (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.wr_entry(wr_entry),
		.match_stream(ev_q.stream),
		.head(head),
		.count(count),
		.full(full),
		.match(match)
	);

	always_comb begin
		cams_eff = (ev_q.cameras == 3'd0) ? cts_pkg::CAMS_LR : ev_q.cameras;
		if (cams_eff[0]) begin
			reason = cts_pkg::RSN_CENTER;
		end else if ((cams_eff & ~cts_pkg::CAMS_LR) != 3'd0) begin
			reason = cts_pkg::RSN_BAD_MASK;
		end else if (!ev_q.stream_known) begin
			reason = cts_pkg::RSN_UNKNOWN;
		end else if (match || (busy_q && act_q.stream == ev_q.stream)) begin
			reason = cts_pkg::RSN_DUPLICATE;
		end else if (full) begin
			reason = cts_pkg::RSN_FULL;
		end else begin
			reason = cts_pkg::RSN_NONE;
		end
		fire = busy_q && settle_q && (ev_q.now_us >= due_q);
		drop = !dropped_q && (el_q >= {32'd0, act_q.pulse});
		over = latched_q && (risen_q == act_q.cams) && ((high_q & await_q) == 2'd0);
		tout = el_q > ({32'd0, act_q.pulse} + {32'd0, margin_q});
		start = !busy_q && (count != '0);
		hold = (!ls_valid_q || ls_q != head.stream) && (head.settle != 32'd0);
		sbit = ev_q.strobe_camera ? 2'b10 : 2'b01;
	end

	// staged word goes out marked last when the event is done
	always_comb begin
		out_row = pend_q;
		out_row.last = (state_q == cts_pkg::ST_DONE);
	end

	// result selection per state
	always_comb begin
		need_emit = 1'b0;
		row = '0;
		case (state_q)
			cts_pkg::ST_ENQ: begin
				need_emit = 1'b1;
				row.out_seq = ev_q.seq;
				row.out_stream = ev_q.stream;
				if (reason != cts_pkg::RSN_NONE) begin
					row.kind = cts_pkg::KIND_REFUSED;
					row.reason_code = reason;
				end else begin
					row.kind = cts_pkg::KIND_ACCEPT;
					row.capture_id = cnt_q + 32'd1;
					row.queue_fill = count[2:0];
				end
			end
			cts_pkg::ST_TICK: begin
				need_emit = fire;
				row = cts_pkg::trig_row(act_q, 1'b1);
			end
			cts_pkg::ST_DROP: begin
				need_emit = drop;
				row = cts_pkg::trig_row(act_q, 1'b0);
			end
			cts_pkg::ST_FIN: begin
				need_emit = over || tout;
				if (over) begin
					row.kind = cts_pkg::KIND_FINISHED;
					row.out_seq = act_q.seq;
					row.out_stream = act_q.stream;
					row.capture_id = act_q.capture_id;
					row.trigger_start = t0_q;
					row.exposure_time = t2_q;
					row.avg_left = finvalid_q ? cts_pkg::avg4(ml0_q, ml2_q) : ml0_q;
					row.avg_right = finvalid_q ? cts_pkg::avg4(ml1_q, ml3_q) : ml1_q;
				end else begin
					row = cts_pkg::reject_row(act_q, cts_pkg::RSN_TIMEOUT);
				end
			end
			cts_pkg::ST_START: begin
				need_emit = start && !hold;
				row = cts_pkg::trig_row(head, 1'b1);
			end
			cts_pkg::ST_CAN: begin
				need_emit = busy_q;
				row = cts_pkg::trig_row(act_q, 1'b0);
			end
			cts_pkg::ST_CAN_FIN: begin
				need_emit = 1'b1;
				row = cts_pkg::reject_row(act_q, cts_pkg::RSN_CANCELLED);
			end
			cts_pkg::ST_DRAIN: begin
				need_emit = (count != '0);
				row = cts_pkg::reject_row(head, cts_pkg::RSN_CANCELLED);
			end
			default: begin
				need_emit = 1'b0;
			end
		endcase
		ctl.push = (state_q == cts_pkg::ST_ENQ) && go && (reason == cts_pkg::RSN_NONE);
		ctl.pop = ((state_q == cts_pkg::ST_START) && go && start) ||
			((state_q == cts_pkg::ST_DRAIN) && go && (count != '0));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cts_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (req_word.func)
						cts_pkg::FUNC_ENQ: state_d = cts_pkg::ST_ENQ;
						cts_pkg::FUNC_TICK: state_d = cts_pkg::ST_TICK;
						cts_pkg::FUNC_STROBE: state_d = cts_pkg::ST_STROBE;
						default: state_d = cts_pkg::ST_CAN;
					endcase
				end
			end
			cts_pkg::ST_ENQ: if (go) state_d = cts_pkg::ST_DONE;
			cts_pkg::ST_TICK: begin
				if (busy_q && settle_q) begin
					if (go) state_d = cts_pkg::ST_DONE;
				end else if (busy_q) begin
					state_d = cts_pkg::ST_DROP;
				end else begin
					state_d = cts_pkg::ST_START;
				end
			end
			cts_pkg::ST_DROP: if (go) state_d = cts_pkg::ST_FIN;
			cts_pkg::ST_FIN: if (go) state_d = cts_pkg::ST_START;
			cts_pkg::ST_START: if (go) state_d = cts_pkg::ST_DONE;
			cts_pkg::ST_CAN: begin
				if (go) state_d = busy_q ? cts_pkg::ST_CAN_FIN : cts_pkg::ST_DRAIN;
			end
			cts_pkg::ST_CAN_FIN: if (go) state_d = cts_pkg::ST_DRAIN;
			cts_pkg::ST_DRAIN: if (count == '0) state_d = cts_pkg::ST_DONE;
			cts_pkg::ST_STROBE: state_d = cts_pkg::ST_DONE;
			cts_pkg::ST_DONE: if (!pend_v_q || out_free) state_d = cts_pkg::ST_IDLE;
			default: state_d = cts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cts_pkg::ST_IDLE;
			ev_q <= '0;
			margin_q <= cts_pkg::MARGIN_RESET;
			cnt_q <= '0;
			act_q <= '0;
			busy_q <= 1'b0;
			dropped_q <= 1'b0;
			settle_q <= 1'b0;
			latched_q <= 1'b0;
			finvalid_q <= 1'b0;
			high_q <= '0;
			risen_q <= '0;
			await_q <= '0;
			ls_valid_q <= 1'b0;
			ls_q <= '0;
			t0_q <= '0;
			due_q <= '0;
			t2_q <= '0;
			el_q <= '0;
			ml0_q <= '0;
			ml1_q <= '0;
			ml2_q <= '0;
			ml3_q <= '0;
			pend_q <= '0;
			pend_v_q <= 1'b0;
			rsp_q <= '0;
			rsp_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				margin_q <= cfg_data;
			end
			// staged result goes out once a newer one shows it was not the last, or marked last when done
			if (out_load) begin
				rsp_q <= out_row;
				rsp_v_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_v_q <= 1'b0;
			end
			if (need_emit && go) begin
				pend_q <= row;
				pend_v_q <= 1'b1;
			end else if ((state_q == cts_pkg::ST_DONE) && out_free) begin
				pend_v_q <= 1'b0;
			end
			case (state_q)
				cts_pkg::ST_IDLE: begin
					if (req_valid) begin
						ev_q <= req_word;
					end
				end
				cts_pkg::ST_ENQ: begin
					if (ctl.push) begin
						cnt_q <= cnt_q + 32'd1;
					end
				end
				cts_pkg::ST_TICK: begin
					if (fire && go) begin
						settle_q <= 1'b0;
						t0_q <= ev_q.now_us;
					end
					el_q <= ev_q.now_us - t0_q;
				end
				cts_pkg::ST_DROP: begin
					if (drop && go) begin
						dropped_q <= 1'b1;
					end
				end
				cts_pkg::ST_FIN: begin
					if ((over || tout) && go) begin
						busy_q <= 1'b0;
						settle_q <= 1'b0;
					end
				end
				cts_pkg::ST_START: begin
					if (start && go) begin
						act_q <= head;
						busy_q <= 1'b1;
						dropped_q <= 1'b0;
						latched_q <= 1'b0;
						finvalid_q <= 1'b0;
						high_q <= high_q & ~head.cams;
						risen_q <= risen_q & ~head.cams;
						await_q <= head.cams;
						ls_valid_q <= 1'b1;
						ls_q <= head.stream;
						settle_q <= hold;
						if (hold) begin
							due_q <= ev_q.now_us + {32'd0, head.settle};
						end else begin
							t0_q <= ev_q.now_us;
						end
					end
				end
				cts_pkg::ST_CAN_FIN: begin
					if (go) begin
						busy_q <= 1'b0;
						settle_q <= 1'b0;
					end
				end
				cts_pkg::ST_STROBE: begin
					if (ev_q.strobe_level) begin
						high_q <= high_q | sbit;
						risen_q <= risen_q | sbit;
						if (!latched_q && ((await_q & sbit) != 2'd0)) begin
							t2_q <= ev_q.now_us;
							ml0_q <= ev_q.mirror_left;
							ml1_q <= ev_q.mirror_right;
							latched_q <= 1'b1;
						end
					end else begin
						if (latched_q && ((await_q & sbit) != 2'd0)) begin
							ml2_q <= ev_q.mirror_left;
							ml3_q <= ev_q.mirror_right;
							finvalid_q <= 1'b1;
						end
						high_q <= high_q & ~sbit;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign req_ready = (state_q == cts_pkg::ST_IDLE);
	assign rsp_valid = rsp_v_q;
	assign rsp_word = rsp_q;

endmodule
`default_nettype wire

@@ rtl/core/cts_checker.sv @@
// Port-level checks for the camera trigger request sequencer, bound to the top level.
`default_nettype none
module cts_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_ready,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire cts_pkg::rsp_word_t rsp_word
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_word))
		else $error("result word changed while stalled");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_word.last |-> !req_ready)
		else $error("new word taken before event's last result");

	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.kind == cts_pkg::KIND_ACCEPT |-> rsp_word.reason_code == 3'd0)
		else $error("accepted word carries a reason");

	a_trig_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.kind != cts_pkg::KIND_TRIGGER |->
		rsp_word.trigger_mask_level == 3'd0)
		else $error("trigger level on non-trigger word");

endmodule

bind camera_trigger_request_sequencer cts_checker u_cts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp_word(rsp_word)
);
`default_nettype wire

@@ tb/sv/camera_trigger_request_sequencer_checker.sv @@
// Checker: watches the request and response channels, predicts each response and compares it.
module camera_trigger_request_sequencer_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic               req_ready,
	input  wire cts_pkg::req_word_t req_word,
	input  wire logic               rsp_valid,
	input  wire logic               rsp_ready,
	input  wire cts_pkg::rsp_word_t rsp_word,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_data,
	output int                      fail_count,
	output int                      pending,
	output int                      rsp_seen
);
	import cts_pkg::*;

	typedef struct {
		logic [15:0] seq;
		logic [7:0]  stream;
		logic [2:0]  cams;
		logic [31:0] pulse;
		logic [31:0] settle;
		logic [31:0] capture_id;
	} slot_t;

	rsp_word_t   rsp_expected[$];
	slot_t       fifo[QUEUE_DEPTH];
	slot_t       cur;
	int          head, count;
	logic [31:0] margin, capture_cnt;
	logic        busy, dropped, settling, latched, fin_valid;
	logic [2:0]  s_high, s_risen, s_await;
	logic        stream_valid;
	logic [7:0]  stream_prev;
	logic [63:0] t_start, t_due, t_expo;
	logic [63:0] m_sl, m_sr, m_fl, m_fr;
	int          mismatches;

	assign pending = rsp_expected.size();
	assign fail_count = mismatches;

	function automatic logic [63:0] mean4(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		logic [16:0] s;
		for (int i = 0; i < 4; i++) begin
			s = {1'b0, a[16*i +: 16]} + {1'b0, b[16*i +: 16]} + 17'd1;
			r[16*i +: 16] = s[16:1];
		end
		return r;
	endfunction

	function automatic rsp_word_t row_of(input logic [2:0] k, input slot_t s);
		rsp_word_t r;
		r = '0;
		r.kind = k;
		r.out_seq = s.seq;
		r.out_stream = s.stream;
		r.capture_id = s.capture_id;
		return r;
	endfunction

	task automatic push_trigger(input logic lvl);
		rsp_word_t r;
		r = row_of(KIND_TRIGGER, cur);
		r.trigger_mask_level = (cur.cams & 3'b110) | {2'b0, lvl};
		rsp_expected.push_back(r);
	endtask

	task automatic push_close(input logic [2:0] rsn);
		rsp_word_t r;
		if (rsn != RSN_NONE) begin
			r = row_of(KIND_REJECTED, cur);
			r.reason_code = rsn;
		end else begin
			r = row_of(KIND_FINISHED, cur);
			r.trigger_start = t_start;
			r.exposure_time = t_expo;
			r.avg_left = fin_valid ? mean4(m_sl, m_fl) : m_sl;
			r.avg_right = fin_valid ? mean4(m_sr, m_fr) : m_sr;
		end
		rsp_expected.push_back(r);
		busy = 0;
		settling = 0;
	endtask

	task automatic launch_next(input logic [63:0] now);
		logic sw;
		if (busy || count == 0)
			return;
		cur = fifo[head];
		head = (head + 1) % QUEUE_DEPTH;
		count--;
		busy = 1;
		dropped = 0;
		latched = 0;
		fin_valid = 0;
		s_high &= ~cur.cams;
		s_risen &= ~cur.cams;
		s_await = cur.cams;
		sw = !stream_valid || stream_prev != cur.stream;
		stream_valid = 1;
		stream_prev = cur.stream;
		if (sw && cur.settle > 0) begin
			settling = 1;
			t_due = now + {32'd0, cur.settle};
		end else begin
			settling = 0;
			t_start = now;
			push_trigger(1'b1);
		end
	endtask

	task automatic predict(input req_word_t w);
		int          n0;
		logic [2:0]  cams, bit_m, rsn;
		logic [63:0] el;
		logic        skip, over;
		rsp_word_t   r;
		slot_t       s;
		n0 = rsp_expected.size();
		case (w.func)
			FUNC_ENQ: begin
				cams = (w.cameras == 3'd0) ? CAMS_LR : w.cameras;
				rsn = RSN_NONE;
				if (cams[0])
					rsn = RSN_CENTER;
				else if (!w.stream_known)
					rsn = RSN_UNKNOWN;
				else begin
					for (int i = 0; i < count; i++)
						if (fifo[(head + i) % QUEUE_DEPTH].stream == w.stream)
							rsn = RSN_DUPLICATE;
					if (busy && cur.stream == w.stream)
						rsn = RSN_DUPLICATE;
					if (rsn == RSN_NONE && count >= QUEUE_DEPTH)
						rsn = RSN_FULL;
				end
				r = '0;
				r.out_seq = w.seq;
				r.out_stream = w.stream;
				if (rsn != RSN_NONE) begin
					r.kind = KIND_REFUSED;
					r.reason_code = rsn;
				end else begin
					capture_cnt++;
					r.kind = KIND_ACCEPT;
					r.capture_id = capture_cnt;
					r.queue_fill = count[2:0];
					s.seq = w.seq;
					s.stream = w.stream;
					s.cams = cams;
					s.pulse = w.pulse_us;
					s.settle = w.settle_us;
					s.capture_id = capture_cnt;
					fifo[(head + count) % QUEUE_DEPTH] = s;
					count++;
				end
				rsp_expected.push_back(r);
			end
			FUNC_TICK: begin
				skip = 0;
				if (busy) begin
					if (settling) begin
						if (w.now_us >= t_due) begin
							settling = 0;
							t_start = w.now_us;
							push_trigger(1'b1);
						end
						skip = 1;
					end else begin
						el = w.now_us - t_start;
						if (!dropped && el >= {32'd0, cur.pulse}) begin
							push_trigger(1'b0);
							dropped = 1;
						end
						over = latched && s_risen == cur.cams && (s_high & s_await) == 0;
						if (over)
							push_close(RSN_NONE);
						else if (el > {32'd0, cur.pulse} + {32'd0, margin})
							push_close(RSN_TIMEOUT);
					end
				end
				if (!skip)
					launch_next(w.now_us);
			end
			FUNC_STROBE: begin
				bit_m = w.strobe_camera ? 3'b100 : 3'b010;
				if (w.strobe_level) begin
					s_high |= bit_m;
					s_risen |= bit_m;
					if (!latched && (s_await & bit_m) != 0) begin
						t_expo = w.now_us;
						m_sl = w.mirror_left;
						m_sr = w.mirror_right;
						latched = 1;
					end
				end else begin
					if (latched && (s_await & bit_m) != 0) begin
						m_fl = w.mirror_left;
						m_fr = w.mirror_right;
						fin_valid = 1;
					end
					s_high &= ~bit_m;
				end
			end
			default: begin
				if (busy) begin
					push_trigger(1'b0);
					push_close(RSN_CANCELLED);
				end
				while (count > 0) begin
					s = fifo[head];
					head = (head + 1) % QUEUE_DEPTH;
					count--;
					r = row_of(KIND_REJECTED, s);
					r.reason_code = RSN_CANCELLED;
					rsp_expected.push_back(r);
				end
			end
		endcase
		if (rsp_expected.size() > n0)
			rsp_expected[rsp_expected.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t e;
		if (!arst_n) begin
			rsp_expected.delete();
			head = 0;
			count = 0;
			margin = MARGIN_RESET;
			capture_cnt = 0;
			busy = 0;
			dropped = 0;
			settling = 0;
			latched = 0;
			fin_valid = 0;
			s_high = 0;
			s_risen = 0;
			s_await = 0;
			stream_valid = 0;
			stream_prev = 0;
			t_start = 0;
			t_due = 0;
			t_expo = 0;
			m_sl = 0;
			m_sr = 0;
			m_fl = 0;
			m_fr = 0;
			mismatches = 0;
			rsp_seen = 0;
		end else begin
			if (cfg_we)
				margin = cfg_data;
			if (rsp_valid && rsp_ready) begin
				rsp_seen++;
				if (rsp_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response word %h", rsp_word);
				end else begin
					e = rsp_expected.pop_front();
					if (e !== rsp_word) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected %p", e);
							$display("          actual   %p", rsp_word);
						end
					end
				end
			end
			if (req_valid && req_ready)
				predict(req_word);
		end
	end
endmodule

@@ tb/sv/camera_trigger_request_sequencer_tb.sv @@
// Testbench top: drives request words, configuration and response stalls, then gives the verdict.
module camera_trigger_request_sequencer_tb;
	import cts_pkg::*;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       req_valid = 0;
	logic       req_ready;
	req_word_t  req_word = '0;
	logic       rsp_valid;
	logic       rsp_ready = 0;
	rsp_word_t  rsp_word;
	logic       cfg_we = 0;
	logic [31:0] cfg_data = '0;
	int         fail_count, pending, rsp_seen;
	int         idle_pct = 38;
	logic       hold_rsp = 0;
	logic [63:0] now_t = 64'd100;
	int         words_sent = 0;
	int         stalled = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	camera_trigger_request_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	camera_trigger_request_sequencer_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen)
	);

	always @(posedge clk) begin
		if (hold_rsp)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stalled <= 0;
		else
			stalled <= stalled + 1;
		if (stalled > 20000) begin
			$display("status: fail");
			$finish;
		end
	end

	// the block is never ready the cycle after a take, so the leading edge costs nothing
	task automatic send(input req_word_t w);
		@(posedge clk);
		while ($urandom_range(99) < idle_pct)
			@(posedge clk);
		req_valid <= 1'b1;
		req_word <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		req_valid <= 1'b0;
		words_sent++;
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_margin(input logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic req_word_t mk_enq(input logic [15:0] sq, input logic [7:0] st,
			input logic [2:0] cm, input logic [31:0] pl, input logic [31:0] stl,
			input logic kn);
		req_word_t w;
		w = '0;
		w.func = FUNC_ENQ;
		w.seq = sq;
		w.stream = st;
		w.cameras = cm;
		w.pulse_us = pl;
		w.settle_us = stl;
		w.stream_known = kn;
		w.now_us = {$urandom, $urandom};
		return w;
	endfunction

	function automatic req_word_t mk_ev(input logic [1:0] f, input logic [63:0] t,
			input logic cam, input logic lvl);
		req_word_t w;
		w = '0;
		w.func = f;
		w.now_us = t;
		w.strobe_camera = cam;
		w.strobe_level = lvl;
		w.mirror_left = {$urandom, $urandom};
		w.mirror_right = {$urandom, $urandom};
		w.seq = 16'($urandom);
		w.stream = 8'($urandom);
		return w;
	endfunction

	task automatic tick(input int adv);
		now_t = now_t + 64'(adv);
		send(mk_ev(FUNC_TICK, now_t, 1'b0, 1'b0));
	endtask

	task automatic capture_cycle();
		logic [2:0] cm;
		cm = ($urandom_range(3) == 0) ? 3'd0 : {2'($urandom_range(1, 3)), 1'b0};
		send(mk_enq(16'($urandom), 8'($urandom_range(0, 5)), cm, $urandom_range(0, 40),
			($urandom_range(2) == 0) ? 32'd0 : $urandom_range(1, 30), 1'b1));
		tick($urandom_range(0, 10));
		tick($urandom_range(0, 40));
		repeat ($urandom_range(1, 4)) begin
			now_t = now_t + 64'($urandom_range(0, 20));
			send(mk_ev(FUNC_STROBE, now_t, 1'($urandom), 1'($urandom)));
		end
		tick($urandom_range(0, 60));
		if ($urandom_range(3) == 0)
			tick($urandom_range(0, 200));
	endtask

	initial begin
		req_word_t w;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: masks, unknown stream, extremes, full, duplicate, cancel
		send(mk_enq(16'hFFFF, 8'hFF, 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send(mk_enq(16'h0000, 8'h00, 3'd7, 32'd0, 32'd0, 1'b1));
		send(mk_enq(16'h1234, 8'h10, 3'd2, 32'd5, 32'd0, 1'b0));
		for (int i = 0; i < 9; i++)
			send(mk_enq(16'(i), 8'(i), 3'(2 * (i % 4)), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send(mk_enq(16'h5555, 8'h03, 3'd4, 32'd1, 32'd1, 1'b1));
		tick(0);
		send(mk_ev(FUNC_CANCEL, 64'd0, 1'b0, 1'b0));
		send(mk_ev(FUNC_CANCEL, 64'd0, 1'b0, 1'b0));
		write_margin(32'd0);
		send(mk_enq(16'hAAAA, 8'h20, 3'd6, 32'd0, 32'd0, 1'b1));
		now_t = 64'hFFFF_FFFF_FFFF_FFF0;
		tick(0);
		send(mk_ev(FUNC_STROBE, now_t + 64'd1, 1'b0, 1'b1));
		send(mk_ev(FUNC_STROBE, now_t + 64'd2, 1'b1, 1'b1));
		send(mk_ev(FUNC_STROBE, now_t + 64'd3, 1'b0, 1'b0));
		send(mk_ev(FUNC_STROBE, now_t + 64'd4, 1'b1, 1'b0));
		tick(20);
		tick(5);
		send(mk_enq(16'h0F0F, 8'h21, 3'd2, 32'd3, 32'd10, 1'b1));
		tick(1);
		send(mk_ev(FUNC_CANCEL, 64'd0, 1'b0, 1'b0));

		write_margin(32'hFFFF_FFFF);
		// receiver holds off while the sender keeps offering words
		fork
			begin
				hold_rsp = 1'b1;
				repeat (300) @(posedge clk);
				hold_rsp = 1'b0;
			end
			begin
				for (int i = 0; i < 10; i++)
					send(mk_enq(16'($urandom), 8'(40 + i), 3'd6, 32'd4, 32'd0, 1'b1));
			end
		join
		send(mk_ev(FUNC_CANCEL, 64'd0, 1'b0, 1'b0));
		write_margin(32'd50);

		// random: mostly well-formed capture cycles, some noise
		idle_pct = 0;
		while (words_sent < 140)
			capture_cycle();
		idle_pct = 38;
		while (words_sent < 305) begin
			if ($urandom_range(9) < 7)
				capture_cycle();
			else begin
				w = mk_ev(2'($urandom), {$urandom, $urandom}, 1'($urandom), 1'($urandom));
				if (w.func == FUNC_ENQ)
					w = mk_enq(16'($urandom), 8'($urandom), 3'($urandom), $urandom,
						$urandom, 1'($urandom));
				send(w);
			end
			if (words_sent > 230 && words_sent < 240)
				write_margin($urandom_range(0, 100));
		end
		send(mk_ev(FUNC_CANCEL, 64'd0, 1'b0, 1'b0));

		drain();
		$display("covered %0d request words and %0d response words, margins 0, 50, max and random",
			words_sent, rsp_seen);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
